/* sv/dfrc_pkg.sv */
package dfrc_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [31:0] MAGIC_RESET = 32'h5745_4447;
  localparam logic [31:0] VERSION_RESET = 32'd1;
  localparam logic [31:0] HASH_START = 32'd5381;
  localparam logic [32:0] HDR_BYTES = 33'd16;
  localparam logic [32:0] COUNT_MAX = '1;
  localparam logic [31:0] LENGTH_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAGIC   = 2'd0,
    REG_VERSION = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_ID    = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_MISMATCH  = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] length;
    logic [31:0] hash;
  } verdict_t;

endpackage

/* sv/dfrc_record.sv */
module dfrc_record
  import dfrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [31:0] expected_magic,
  input  logic [31:0] expected_version,
  output verdict_t    verdict
);

  logic [32:0] byte_count, byte_count_next;
  logic [31:0] header_magic, header_magic_next;
  logic [31:0] header_version, header_version_next;
  logic [31:0] header_length, header_length_next;
  logic [31:0] header_checksum, header_checksum_next;
  logic [31:0] running_hash, running_hash_next;
  logic [31:0] len_now;
  logic [31:0] len_next;
  logic [33:0] payload_end;
  logic [33:0] payload_end_next;
  logic        in_header;
  logic        in_payload;

  assign len_now = header_length & LENGTH_MASK;
  assign payload_end = {1'b0, HDR_BYTES} + {2'b00, len_now};
  assign in_header = byte_count < HDR_BYTES;
  assign in_payload = !in_header && ({1'b0, byte_count} < payload_end);

  always_comb begin
    header_magic_next = header_magic;
    header_version_next = header_version;
    header_length_next = header_length;
    header_checksum_next = header_checksum;
    running_hash_next = running_hash;
    if (in_header) begin
      case (byte_count[3:2])
        2'd0: header_magic_next[byte_count[1:0]*8 +: 8] = data_byte;
        2'd1: header_version_next[byte_count[1:0]*8 +: 8] = data_byte;
        2'd2: header_length_next[byte_count[1:0]*8 +: 8] = data_byte;
        default: header_checksum_next[byte_count[1:0]*8 +: 8] = data_byte;
      endcase
    end else if (in_payload) begin
      running_hash_next = (running_hash << 5) + running_hash + {24'd0, data_byte};
    end
    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 33'd1;
  end

  assign len_next = header_length_next & LENGTH_MASK;
  assign payload_end_next = {1'b0, HDR_BYTES} + {2'b00, len_next};

  always_comb begin
    verdict.hash = running_hash_next;
    verdict.length = len_next;
    if (byte_count_next < HDR_BYTES) begin
      verdict.status = ST_SHORT;
      verdict.length = '0;
    end else if (header_magic_next != expected_magic ||
                 header_version_next != expected_version) begin
      verdict.status = ST_BAD_ID;
    end else if ({1'b0, byte_count_next} < payload_end_next) begin
      verdict.status = ST_TRUNCATED;
    end else if (running_hash_next != header_checksum_next) begin
      verdict.status = ST_MISMATCH;
    end else begin
      verdict.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_count <= '0;
      header_magic <= '0;
      header_version <= '0;
      header_length <= '0;
      header_checksum <= '0;
      running_hash <= HASH_START;
    end else if (accept) begin
      byte_count <= byte_count_next;
      header_magic <= header_magic_next;
      header_version <= header_version_next;
      header_length <= header_length_next;
      header_checksum <= header_checksum_next;
      running_hash <= running_hash_next;
    end
  end

endmodule

/* sv/djb2_framed_record_checker.sv */
// Framed record checker: takes one byte per cycle, header (magic, version,
// payload length, checksum; little-endian words) then payload, and hashes the
// payload with djb2. On the byte flagged last it issues one verdict (status,
// header length, computed hash) in the next cycle through an output register.
// Throughput is one byte per cycle; the hash update and header capture feed
// the record state registers combinationally. Input stalls only while a
// verdict waits in the output register and out_ready is low. Configuration
// writes are always taken; indexes beyond the register list are dropped.
module djb2_framed_record_checker
  import dfrc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                status,
  output logic [31:0]               payload_length,
  output logic [31:0]               computed_hash,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);

  logic [31:0] expected_magic;
  logic [31:0] expected_version;
  logic        in_accept;
  verdict_t    verdict;
  verdict_t    result;

  assign cfg_ready = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= MAGIC_RESET;
      expected_version <= VERSION_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAGIC: expected_magic <= cfg_data;
        REG_VERSION: expected_version <= cfg_data;
        default: ;
      endcase
    end
  end

  dfrc_record u_record (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_accept),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .expected_magic   (expected_magic),
    .expected_version (expected_version),
    .verdict          (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last_byte) begin
      result <= verdict;
    end
  end

  assign status = result.status;
  assign payload_length = result.length;
  assign computed_hash = result.hash;

endmodule

/* sv/dfrc_checker.sv */
module dfrc_checker
  import dfrc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] payload_length,
  input logic [31:0] computed_hash
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // a last byte taken always yields a verdict
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> out_valid)
    else $error("last byte without verdict");

  // a held verdict blocks new bytes
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while verdict held");

  // short header carries no length and the start hash
  a_short_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SHORT |-> payload_length == '0 && computed_hash == HASH_START)
    else $error("short header fields wrong");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
    $stable(payload_length) && $stable(computed_hash))
    else $error("verdict dropped or changed while stalled");

endmodule

bind djb2_framed_record_checker dfrc_checker u_dfrc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .last_byte      (last_byte),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .payload_length (payload_length),
  .computed_hash  (computed_hash)
);

/* test/frame_verdict_monitor.sv */
`timescale 1ns / 1ps
module frame_verdict_monitor
  import dfrc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [2:0]                status,
  input  logic [31:0]               payload_length,
  input  logic [31:0]               computed_hash,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  output int                        fail_count,
  output int                        due_count,
  output int                        verdict_count
);

  logic [31:0] magic_reg;
  logic [31:0] version_reg;
  logic [32:0] rec_count;
  logic [31:0] hdr_magic;
  logic [31:0] hdr_version;
  logic [31:0] hdr_length;
  logic [31:0] hdr_checksum;
  logic [31:0] run_hash;
  verdict_t    verdicts_due[$];
  verdict_t    head;
  logic        off;
  int          fails;
  int          seen;

  task automatic clear_record();
    rec_count = '0;
    hdr_magic = '0;
    hdr_version = '0;
    hdr_length = '0;
    hdr_checksum = '0;
    run_hash = HASH_START;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    logic [31:0] lane;
    logic [31:0] len_used;
    verdict_t    v;
    lane = 32'(b) << (8 * rec_count[1:0]);
    len_used = hdr_length & LENGTH_MASK;
    if (rec_count < HDR_BYTES) begin
      case (rec_count[3:2])
        2'd0: hdr_magic = hdr_magic | lane;
        2'd1: hdr_version = hdr_version | lane;
        2'd2: hdr_length = hdr_length | lane;
        default: hdr_checksum = hdr_checksum | lane;
      endcase
    end else if (rec_count - HDR_BYTES < {1'b0, len_used}) begin
      run_hash = (run_hash << 5) + run_hash + 32'(b);
    end
    if (rec_count != COUNT_MAX) rec_count = rec_count + 33'd1;
    if (fin) begin
      v.length = '0;
      v.hash = run_hash;
      if (rec_count < HDR_BYTES) begin
        v.status = ST_SHORT;
      end else begin
        len_used = hdr_length & LENGTH_MASK;
        v.length = len_used;
        if (hdr_magic != magic_reg || hdr_version != version_reg) v.status = ST_BAD_ID;
        else if (rec_count < HDR_BYTES + {1'b0, len_used}) v.status = ST_TRUNCATED;
        else if (run_hash != hdr_checksum) v.status = ST_MISMATCH;
        else v.status = ST_OK;
      end
      verdicts_due.push_back(v);
      clear_record();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      magic_reg = MAGIC_RESET;
      version_reg = VERSION_RESET;
      clear_record();
      verdicts_due.delete();
      fails = 0;
      seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: verdict with none due: status %0d length %0d hash %h",
                   $time, status, payload_length, computed_hash);
          fails++;
        end else begin
          head = verdicts_due.pop_front();
          seen++;
          off = 1'b0;
          if (status !== head.status) begin
            $display("%0t: status expected %0d actual %0d", $time, head.status, status);
            off = 1'b1;
          end
          if (payload_length !== head.length) begin
            $display("%0t: payload_length expected %0d actual %0d",
                     $time, head.length, payload_length);
            off = 1'b1;
          end
          if (computed_hash !== head.hash) begin
            $display("%0t: computed_hash expected %h actual %h",
                     $time, head.hash, computed_hash);
            off = 1'b1;
          end
          if (off) fails++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAGIC: magic_reg = cfg_data;
          REG_VERSION: version_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) absorb_byte(data_byte, last_byte);
    end
    fail_count <= fails;
    due_count <= verdicts_due.size();
    verdict_count <= seen;
  end

endmodule

/* test/djb2_framed_record_checker_tb.sv */
`timescale 1ns / 1ps
module djb2_framed_record_checker_tb;
  import dfrc_pkg::*;

  typedef enum int {
    REC_GOOD,
    REC_BAD_SUM,
    REC_TRUNC,
    REC_BAD_MAGIC,
    REC_BAD_VER,
    REC_SHORT,
    REC_NOISE
  } rec_kind_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 500;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic [7:0]                data_byte = '0;
  logic                      last_byte = 1'b0;
  logic                      out_ready = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [31:0]               cfg_data = '0;
  logic                      in_ready;
  logic                      out_valid;
  logic                      cfg_ready;
  logic [2:0]                status;
  logic [31:0]               payload_length;
  logic [31:0]               computed_hash;

  int fail_count;
  int due_count;
  int verdict_count;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_epoch = 0;
  int epoch_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int records_sent = 0;

  logic [31:0] magic_now = MAGIC_RESET;
  logic [31:0] version_now = VERSION_RESET;
  logic [7:0]  frame[$];

  djb2_framed_record_checker DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .payload_length(payload_length), .computed_hash(computed_hash),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  frame_verdict_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .payload_length(payload_length), .computed_hash(computed_hash),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .due_count(due_count), .verdict_count(verdict_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off each time hold_epoch moves
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      epoch_seen = hold_epoch;
    end else if (hold_epoch != epoch_seen) begin
      epoch_seen = hold_epoch;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_item(frame[i], i == frame.size() - 1);
    records_sent++;
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) frame.push_back(w[8*i +: 8]);
  endtask

  task automatic send_record(input rec_kind_t kind, input logic [31:0] claimed,
                             input int sent, input int trail);
    logic [31:0] hash;
    logic [31:0] magic;
    logic [31:0] version;
    logic [31:0] sum;
    logic [7:0]  body[$];
    logic [7:0]  b;
    frame.delete();
    hash = HASH_START;
    magic = magic_now;
    version = version_now;
    if (kind == REC_SHORT || kind == REC_NOISE) begin
      repeat (sent) frame.push_back(8'($urandom));
    end else begin
      repeat (sent) begin
        b = 8'($urandom);
        body.push_back(b);
        hash = (hash << 5) + hash + 32'(b);
      end
      sum = hash;
      case (kind)
        REC_BAD_SUM: sum = hash ^ (32'd1 << $urandom_range(31));
        REC_BAD_MAGIC: magic = magic ^ (32'd1 << $urandom_range(31));
        REC_BAD_VER: version = version ^ (32'd1 << $urandom_range(31));
        REC_TRUNC: sum = $urandom;
        default: ;
      endcase
      push_word(magic);
      push_word(version);
      push_word(claimed);
      push_word(sum);
      foreach (body[i]) frame.push_back(body[i]);
      repeat (trail) frame.push_back(8'($urandom));
    end
    send_frame();
  endtask

  task automatic random_record();
    int pick;
    int plen;
    int trail;
    logic [31:0] claimed;
    pick = $urandom_range(99);
    plen = ($urandom_range(9) == 0) ? $urandom_range(60, 40) : $urandom_range(12, 0);
    trail = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
    claimed = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF : plen + 1 + $urandom_range(5);
    if (pick < 40) send_record(REC_GOOD, plen, plen, trail);
    else if (pick < 52) send_record(REC_BAD_SUM, plen, plen, trail);
    else if (pick < 64) send_record(REC_TRUNC, claimed, plen, 0);
    else if (pick < 72) send_record(REC_BAD_MAGIC, plen, plen, trail);
    else if (pick < 80) send_record(REC_BAD_VER, plen, plen, trail);
    else if (pick < 88) send_record(REC_SHORT, 0, $urandom_range(15, 1), 0);
    else send_record(REC_NOISE, 0, $urandom_range(40, 1), 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MAGIC) magic_now = value;
    else if (idx == REG_VERSION) version_now = value;
  endtask

  task automatic configure(input logic [31:0] magic, input logic [31:0] version,
                           input bit spare);
    write_reg(REG_MAGIC, magic);
    write_reg(REG_VERSION, version);
    if (spare) begin
      write_reg(REG_SPARE_2, $urandom);
      write_reg(REG_SPARE_3, $urandom);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic random_phase(input int tx, input int rx, input bit pressure);
    int start_bytes;
    int count;
    tx_idle_pct = tx;
    rx_stall_pct <= rx;
    start_bytes = bytes_sent;
    count = 0;
    if (pressure) hold_epoch <= hold_epoch + 1;
    while (bytes_sent - start_bytes < 90 || count < 3) begin
      if (pressure && count == 2) drain();
      random_record();
      count++;
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    configure(MAGIC_RESET, VERSION_RESET, 1'b0);

    frame.delete();
    frame.push_back(8'hFF);
    send_frame();
    frame.delete();
    repeat (15) frame.push_back(8'h00);
    send_frame();
    send_record(REC_GOOD, 0, 0, 0);
    send_record(REC_GOOD, 3, 3, 2);
    send_record(REC_BAD_MAGIC, 1, 1, 0);
    send_record(REC_BAD_VER, 1, 1, 0);
    send_record(REC_TRUNC, 32'hFFFF_FFFF, 2, 0);
    send_record(REC_BAD_SUM, 2, 2, 0);
    send_record(REC_GOOD, 1, 1, 40);
    drain();

    configure('0, '0, 1'b0);
    random_phase(0, 0, 1'b0);
    configure('1, '1, 1'b1);
    random_phase(62, 0, 1'b0);
    configure($urandom, $urandom, 1'b0);
    random_phase(0, 62, 1'b0);
    configure($urandom, $urandom, 1'b1);
    random_phase(33, 33, 1'b0);
    configure(MAGIC_RESET, VERSION_RESET, 1'b0);
    random_phase(33, 33, 1'b1);

    $display("Summary: %0d bytes in %0d records, %0d verdicts compared", bytes_sent,
             records_sent, verdict_count);
    $display("  under free-running, sender-idle, receiver-stall, mixed and hold-off traffic");
    if (fail_count == 0 && due_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
